// File: rtl/vcmw_pkg.sv
// shared constants and types for the velocity command mux with watchdog
package vcmw_pkg;

    localparam int AGE_WIDTH_DEF = 16;
    localparam int VEL_WIDTH_DEF = 32;
    localparam int FIELD_W       = 32;
    localparam int NCOMP         = 6;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int KIND_W        = 2;
    localparam int SRC_W         = 2;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_PRIMARY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DOCKING = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SELECT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd3;

    localparam logic [SRC_W-1:0] SRC_PRIMARY = 2'd0;
    localparam logic [SRC_W-1:0] SRC_DOCKING = 2'd1;

    localparam logic [CFG_W-1:0] TIMEOUT_RESET  = 16'd200;
    localparam logic [CFG_W-1:0] COOLDOWN_RESET = 16'd500;
    localparam logic [SRC_W-1:0] DEFAULT_RESET  = SRC_PRIMARY;

    typedef logic [NCOMP-1:0][FIELD_W-1:0] vel_vec_t;

    typedef struct packed {
        logic             cmd;
        logic             tick;
        logic             judge;
        logic [CFG_W-1:0] timeout;
        logic [CFG_W-1:0] cooldown;
    } src_ctrl_t;

    typedef struct packed {
        logic emit;
        logic forced;
    } src_stat_t;

endpackage

// File: rtl/velocity_command_mux_watchdog_core.sv
// top level: input register, two sources, source select and result register
// pipeline: two register stages; a tick result passes the input register, then the result register, onto m_tvalid
// throughput: one transaction per cycle while m_tready stays high
// a stalled result holds the input register and drops s_tready after at most one more transaction
// reset: timeout 200, cooldown 500, primary source active, both sources unseen
module velocity_command_mux_watchdog_core #(
    parameter int AGE_WIDTH = vcmw_pkg::AGE_WIDTH_DEF,
    parameter int VEL_WIDTH = vcmw_pkg::VEL_WIDTH_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // lin_x, lin_y, lin_z, ang_x, ang_y, ang_z
    input  logic [vcmw_pkg::NCOMP*vcmw_pkg::FIELD_W-1:0]  s_tdata,
    // kind, chosen_source
    input  logic [vcmw_pkg::KIND_W+vcmw_pkg::SRC_W-1:0]   s_tuser,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y, out_ang_z
    output logic [vcmw_pkg::NCOMP*vcmw_pkg::FIELD_W-1:0]  m_tdata,
    // forced_zero
    output logic [0:0]                                    m_tuser,
    input  logic                                          cfg_valid,
    output logic                                          cfg_ready,
    input  logic [vcmw_pkg::CFG_IDX_W-1:0]                cfg_index,
    input  logic [vcmw_pkg::CFG_W-1:0]                    cfg_data
);
    import vcmw_pkg::*;

    logic              in_valid_reg;
    logic [KIND_W-1:0] in_kind_reg;
    logic [SRC_W-1:0]  in_sel_reg;
    vel_vec_t          in_vel_reg;
    logic [CFG_W-1:0]  timeout_reg;
    logic [CFG_W-1:0]  cooldown_reg;
    logic [SRC_W-1:0]  active_reg;
    logic              advance;
    logic              out_free;
    logic              is_tick;
    logic              act_primary;
    logic              act_docking;
    src_ctrl_t         p_ctrl;
    src_ctrl_t         d_ctrl;
    src_stat_t         p_stat;
    src_stat_t         d_stat;
    vel_vec_t          p_vel;
    vel_vec_t          d_vel;
    logic              res_valid;
    logic              res_forced;
    vel_vec_t          res_vel;
    logic              cfg_wr;

    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    assign is_tick     = advance && (in_kind_reg == KIND_TICK);
    assign act_primary = (active_reg == SRC_PRIMARY);
    assign act_docking = (active_reg == SRC_DOCKING);

    assign p_ctrl.cmd      = advance && (in_kind_reg == KIND_PRIMARY);
    assign p_ctrl.tick     = is_tick;
    assign p_ctrl.judge    = is_tick && act_primary;
    assign p_ctrl.timeout  = timeout_reg;
    assign p_ctrl.cooldown = cooldown_reg;

    assign d_ctrl.cmd      = advance && (in_kind_reg == KIND_DOCKING);
    assign d_ctrl.tick     = is_tick;
    assign d_ctrl.judge    = is_tick && act_docking;
    assign d_ctrl.timeout  = timeout_reg;
    assign d_ctrl.cooldown = cooldown_reg;

    vcmw_src #(
        .AGE_WIDTH (AGE_WIDTH),
        .VEL_WIDTH (VEL_WIDTH)
    ) u_primary (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (p_ctrl),
        .vel_in  (in_vel_reg),
        .stat    (p_stat),
        .vel_out (p_vel)
    );

    vcmw_src #(
        .AGE_WIDTH (AGE_WIDTH),
        .VEL_WIDTH (VEL_WIDTH)
    ) u_docking (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (d_ctrl),
        .vel_in  (in_vel_reg),
        .stat    (d_stat),
        .vel_out (d_vel)
    );

    always_comb
    begin
        res_valid  = is_tick;
        res_forced = 1'b1;
        res_vel    = '0;
        if (act_primary)
        begin
            res_valid  = is_tick && p_stat.emit;
            res_forced = p_stat.forced;
            res_vel    = p_stat.forced ? '0 : p_vel;
        end
        else if (act_docking)
        begin
            res_valid  = is_tick && d_stat.emit;
            res_forced = d_stat.forced;
            res_vel    = d_stat.forced ? '0 : d_vel;
        end
    end

    vcmw_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .res_vel    (res_vel),
        .res_forced (res_forced),
        .out_free   (out_free),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_kind_reg <= s_tuser[KIND_W-1:0];
            in_sel_reg  <= s_tuser[KIND_W+SRC_W-1:KIND_W];
            in_vel_reg  <= s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg  <= TIMEOUT_RESET;
            cooldown_reg <= COOLDOWN_RESET;
            active_reg   <= DEFAULT_RESET;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    REG_TIMEOUT:  timeout_reg  <= cfg_data;
                    REG_COOLDOWN: cooldown_reg <= cfg_data;
                    REG_DEFAULT:  active_reg   <= cfg_data[SRC_W-1:0];
                    default:      ;
                endcase
            end
            if (advance && (in_kind_reg == KIND_SELECT)
                && ((in_sel_reg == SRC_PRIMARY) || (in_sel_reg == SRC_DOCKING)))
            begin
                active_reg <= in_sel_reg;
            end
        end
    end

    a_forced_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("forced result carries nonzero velocity");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && m_tvalid && !m_tready))
        else $error("input stalled without a blocked result");

    a_result_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (advance && (in_kind_reg == KIND_TICK)))
        else $error("result produced by a non-tick transaction");

endmodule

// File: rtl/vcmw_src.sv
// per-source command store, age counters and stale guard
module vcmw_src #(
    parameter int AGE_WIDTH = vcmw_pkg::AGE_WIDTH_DEF,
    parameter int VEL_WIDTH = vcmw_pkg::VEL_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  vcmw_pkg::src_ctrl_t ctrl,
    input  vcmw_pkg::vel_vec_t  vel_in,
    output vcmw_pkg::src_stat_t stat,
    output vcmw_pkg::vel_vec_t  vel_out
);
    import vcmw_pkg::*;

    localparam int CMP_W = (AGE_WIDTH > CFG_W) ? AGE_WIDTH : CFG_W;

    logic [NCOMP-1:0][VEL_WIDTH-1:0] store_reg;
    logic                            seen_reg;
    logic                            guard_reg;
    logic                            guard_next;
    logic [AGE_WIDTH-1:0]            age_reg;
    logic [AGE_WIDTH-1:0]            age_next;
    logic [AGE_WIDTH-1:0]            gage_reg;
    logic [AGE_WIDTH-1:0]            gage_next;
    logic [AGE_WIDTH-1:0]            age_inc;
    logic [AGE_WIDTH-1:0]            gage_inc;
    logic                            fresh;
    logic                            first_stale;
    logic                            guarding;

    assign age_inc  = (age_reg == '1) ? age_reg : age_reg + 1'b1;
    assign gage_inc = (gage_reg == '1) ? gage_reg : gage_reg + 1'b1;

    assign fresh       = seen_reg && (CMP_W'(age_inc) < CMP_W'(ctrl.timeout));
    assign first_stale = seen_reg && !guard_reg;
    assign guarding    = guard_reg && (CMP_W'(gage_inc) < CMP_W'(ctrl.cooldown));

    assign stat.emit   = fresh || first_stale || guarding;
    assign stat.forced = !fresh;

    always_comb
    begin
        for (int i = 0; i < NCOMP; i++)
        begin
            vel_out[i] = FIELD_W'(store_reg[i]);
        end
    end

    always_comb
    begin
        age_next   = age_reg;
        gage_next  = gage_reg;
        guard_next = guard_reg;
        if (ctrl.cmd)
        begin
            age_next   = '0;
            guard_next = 1'b0;
        end
        else if (ctrl.tick)
        begin
            age_next = age_inc;
            if (guard_reg)
            begin
                gage_next = gage_inc;
            end
            if (ctrl.judge)
            begin
                if (fresh)
                begin
                    guard_next = 1'b0;
                end
                else if (first_stale)
                begin
                    guard_next = 1'b1;
                    gage_next  = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= 1'b0;
            guard_reg <= 1'b0;
            age_reg   <= '0;
            gage_reg  <= '0;
        end
        else
        begin
            guard_reg <= guard_next;
            age_reg   <= age_next;
            gage_reg  <= gage_next;
            if (ctrl.cmd)
            begin
                seen_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.cmd)
        begin
            for (int i = 0; i < NCOMP; i++)
            begin
                store_reg[i] <= VEL_WIDTH'(vel_in[i]);
            end
        end
    end

    a_guard_needs_seen: assert property (@(posedge clk) disable iff (!rst_n)
        guard_reg |-> seen_reg)
        else $error("guard set on a source never commanded");

    a_cmd_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.cmd |=> (age_reg == '0) && !guard_reg)
        else $error("command did not clear age and guard");

    a_idle_tick_keeps_guard: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.tick && !ctrl.judge) |=> $stable(guard_reg))
        else $error("guard changed on a tick for an inactive source");

endmodule

// File: rtl/vcmw_out_stage.sv
// result register on the master side
module vcmw_out_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          res_valid,
    input  vcmw_pkg::vel_vec_t            res_vel,
    input  logic                          res_forced,
    output logic                          out_free,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [vcmw_pkg::NCOMP*vcmw_pkg::FIELD_W-1:0] m_tdata,
    output logic [0:0]                    m_tuser
);
    import vcmw_pkg::*;

    logic     valid_reg;
    vel_vec_t vel_reg;
    logic     forced_reg;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = vel_reg;
    assign m_tuser  = forced_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_valid)
        begin
            vel_reg    <= res_vel;
            forced_reg <= res_forced;
        end
    end

endmodule
